@@ hw/rtl/water_presence_classifier_top_assert.svh @@
// assertion macros shared by the water presence classifier checkers
`ifndef WATER_PRESENCE_CLASSIFIER_TOP_ASSERT_SVH
`define WATER_PRESENCE_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define WPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wpc assertion failed");

// next-cycle implication, disabled while in reset
`define WPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wpc assertion failed");

`endif

@@ hw/rtl/wpc_pkg.sv @@
// shared types and constants of the water presence classifier
`timescale 1ns / 1ps

package wpc_pkg;

    localparam int CHANNELS   = 4;
    localparam int WINDOW     = 10;
    localparam int CH_W       = 2;
    localparam int SAMPLE_W   = 12;
    localparam int PTR_W      = $clog2(WINDOW);
    localparam int ADDR_W     = CH_W + PTR_W;
    localparam int RAM_DEPTH  = 1 << ADDR_W;
    localparam int DROP_W     = SAMPLE_W + 1;
    localparam int LEVEL_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WET_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_LIMIT    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REWET_FLOOR   = CFG_IDX_W'(2);

    localparam logic [SAMPLE_W-1:0] WET_THRESHOLD_RST = SAMPLE_W'(1000);
    localparam logic [SAMPLE_W-1:0] FALL_LIMIT_RST    = SAMPLE_W'(50);
    localparam logic [SAMPLE_W-1:0] REWET_FLOOR_RST   = SAMPLE_W'(500);

    typedef enum logic [LEVEL_W-1:0] {
        LVL_DRY    = 2'd0,
        LVL_WET    = 2'd1,
        LVL_DRYING = 2'd2
    } level_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] wet_threshold;
        logic [SAMPLE_W-1:0] fall_limit;
        logic [SAMPLE_W-1:0] rewet_floor;
    } cfg_t;

    typedef struct packed {
        logic                valid;
        logic                present;
        logic                full;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] smp;
    } ring_stage_t;

endpackage

@@ hw/rtl/water_presence_classifier_top.sv @@
// top level of the water presence classifier
// channels: s_ stream takes one sample per transaction (tuser channel, tdata sample),
//   m_ stream gives one result per input transaction (tuser channel,
//   tdata level state and channel 0 wet indicator), cfg_ writes one threshold register
// result path: a transaction is registered in the ring stage, then in the m_ output register
// throughput: one transaction per cycle while m_tready holds, set by the single write
//   and single read of the sample ring memory in the cycle the sample is taken
// each channel keeps its last samples in a ring inside one ram; the sample from one
//   window back is read while the new one is written, and the state update uses it
//   when the new sample leaves the middle stage
// reset: pointers, full marks, channel states, valid flags and cfg registers reset; the ring
//   contents are not cleared and are only used after the ring has been filled
// stall: a held result keeps the output register; one more transaction sits in the
//   middle stage, after which s_tready drops until m_tready returns
// cfg writes are always ready and are meant for when no transaction is in flight
`timescale 1ns / 1ps

module water_presence_classifier_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wpc_pkg::S_TDATA_W-1:0] s_tdata,   // sample[11:0], zero fill
    input  logic [wpc_pkg::CH_W-1:0]      s_tuser,   // channel[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wpc_pkg::M_TDATA_W-1:0] m_tdata,   // level_state[1:0], indicator[2], zero fill
    output logic [wpc_pkg::CH_W-1:0]      m_tuser,   // channel_out[1:0]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wpc_pkg::SAMPLE_W-1:0]  cfg_data
);
    import wpc_pkg::*;

    cfg_t                cfg_reg;
    ring_stage_t         stage;
    logic [SAMPLE_W-1:0] old_smp;
    logic                stage_adv;
    logic [LEVEL_W-1:0]  out_level;
    logic                out_ind;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wet_threshold <= WET_THRESHOLD_RST;
            cfg_reg.fall_limit    <= FALL_LIMIT_RST;
            cfg_reg.rewet_floor   <= REWET_FLOOR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WET_THRESHOLD: cfg_reg.wet_threshold <= cfg_data;
                CFG_FALL_LIMIT:    cfg_reg.fall_limit    <= cfg_data;
                CFG_REWET_FLOOR:   cfg_reg.rewet_floor   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    wpc_ring u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_ch     (s_tuser),
        .in_smp    (s_tdata[SAMPLE_W-1:0]),
        .stage_adv (stage_adv),
        .stage_o   (stage),
        .old_smp   (old_smp)
    );

    wpc_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stage_i   (stage),
        .old_smp   (old_smp),
        .cfg       (cfg_reg),
        .stage_adv (stage_adv),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ch    (m_tuser),
        .out_level (out_level),
        .out_ind   (out_ind)
    );

    assign m_tdata = M_TDATA_W'({out_ind, out_level});

endmodule

@@ hw/rtl/wpc_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module wpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/wpc_ring.sv @@
// per-channel sample rings: pointer update, ring write and oldest-sample read
`timescale 1ns / 1ps

module wpc_ring (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [wpc_pkg::CH_W-1:0]     in_ch,
    input  logic [wpc_pkg::SAMPLE_W-1:0] in_smp,
    input  logic                         stage_adv,
    output wpc_pkg::ring_stage_t         stage_o,
    output logic [wpc_pkg::SAMPLE_W-1:0] old_smp
);
    import wpc_pkg::*;

    localparam logic [CH_W:0]    CH_COUNT = (CH_W + 1)'(CHANNELS);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

    logic [PTR_W-1:0]    ptr_reg [CHANNELS];
    logic [CHANNELS-1:0] full_reg;
    ring_stage_t         stage_reg;

    logic              accept;
    logic              present;
    logic [PTR_W-1:0]  ptr_cur;
    logic [PTR_W-1:0]  ptr_nxt;
    logic              wrap;
    logic              full_nxt;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;

    assign in_ready = !stage_reg.valid || stage_adv;
    assign accept   = in_valid && in_ready;
    assign present  = {1'b0, in_ch} < CH_COUNT;

    always_comb begin
        ptr_cur  = ptr_reg[in_ch];
        wrap     = (ptr_cur == PTR_LAST);
        ptr_nxt  = wrap ? '0 : ptr_cur + 1'b1;
        full_nxt = full_reg[in_ch] || wrap;
        we       = accept && present;
        waddr    = {in_ch, ptr_cur};
        raddr    = {in_ch, (full_nxt ? ptr_nxt : PTR_W'(0))};
    end

    wpc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ring_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (in_smp),
        .re    (accept),
        .raddr (raddr),
        .rdata (old_smp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                ptr_reg[i] <= '0;
            end
            full_reg <= '0;
        end else if (we) begin
            ptr_reg[in_ch]  <= ptr_nxt;
            full_reg[in_ch] <= full_nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (accept) begin
            stage_reg.valid <= 1'b1;
        end else if (stage_adv) begin
            stage_reg.valid <= 1'b0;
        end
        if (accept) begin
            stage_reg.present <= present;
            stage_reg.full    <= full_nxt;
            stage_reg.ch      <= in_ch;
            stage_reg.smp     <= in_smp;
        end
    end

    assign stage_o = stage_reg;

endmodule

@@ hw/rtl/wpc_classify.sv @@
// wet, drying and dry state update per channel and the output register
`timescale 1ns / 1ps

module wpc_classify (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wpc_pkg::ring_stage_t          stage_i,
    input  logic [wpc_pkg::SAMPLE_W-1:0]  old_smp,
    input  wpc_pkg::cfg_t                 cfg,
    output logic                          stage_adv,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [wpc_pkg::CH_W-1:0]      out_ch,
    output logic [wpc_pkg::LEVEL_W-1:0]   out_level,
    output logic                          out_ind
);
    import wpc_pkg::*;

    logic [CHANNELS-1:0] wet_reg;
    logic [CHANNELS-1:0] drying_reg;
    logic [CHANNELS-1:0] wet_next;
    logic [CHANNELS-1:0] drying_next;

    logic               out_valid_reg;
    logic [CH_W-1:0]    out_ch_reg;
    level_t             out_level_reg;
    logic               out_ind_reg;

    logic signed [DROP_W-1:0] drop;
    logic signed [DROP_W-1:0] rate_s;
    logic                     wet_cur;
    logic                     drying_cur;
    logic                     wet_new;
    logic                     drying_new;
    level_t                   level;
    logic                     update;

    assign stage_adv = !out_valid_reg || out_ready;
    assign update    = stage_i.valid && stage_adv;

    always_comb begin
        drop       = $signed({1'b0, old_smp}) - $signed({1'b0, stage_i.smp});
        rate_s     = $signed({1'b0, cfg.fall_limit});
        wet_cur    = wet_reg[stage_i.ch];
        drying_cur = drying_reg[stage_i.ch];
        wet_new    = wet_cur;
        drying_new = drying_cur;
        if (drying_cur) begin
            if (stage_i.smp <= cfg.wet_threshold) begin
                drying_new = 1'b0;
            end else if (stage_i.full && (stage_i.smp > cfg.rewet_floor)
                         && (drop <= $signed(DROP_W'(0)))) begin
                drying_new = 1'b0;
                wet_new    = 1'b1;
            end
        end else if (!wet_cur && (stage_i.smp > cfg.wet_threshold)) begin
            wet_new = 1'b1;
        end else if (wet_cur && stage_i.full) begin
            if (drop > rate_s) begin
                wet_new    = 1'b0;
                drying_new = 1'b1;
            end
        end

        wet_next    = wet_reg;
        drying_next = drying_reg;
        level       = LVL_DRY;
        if (stage_i.present) begin
            wet_next[stage_i.ch]    = wet_new;
            drying_next[stage_i.ch] = drying_new;
            if (wet_new) begin
                level = LVL_WET;
            end else if (drying_new) begin
                level = LVL_DRYING;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wet_reg       <= '0;
            drying_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (update) begin
                wet_reg    <= wet_next;
                drying_reg <= drying_next;
            end
            if (stage_adv) begin
                out_valid_reg <= stage_i.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (update) begin
            out_ch_reg    <= stage_i.ch;
            out_level_reg <= level;
            out_ind_reg   <= wet_next[0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ch    = out_ch_reg;
    assign out_level = out_level_reg;
    assign out_ind   = out_ind_reg;

endmodule

@@ hw/rtl/wpc_checker.sv @@
// port-level checks of the water presence classifier, bound to the top level
`timescale 1ns / 1ps
`include "water_presence_classifier_top_assert.svh"

module wpc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wpc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [wpc_pkg::CH_W-1:0]      m_tuser
);
    import wpc_pkg::*;

    `WPC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    `WPC_ASSERT_SAME(a_ind_wet, aclk, aresetn,
                     m_tvalid && (m_tuser == '0) && (m_tdata[1:0] == LVL_WET), m_tdata[2])

    `WPC_ASSERT_SAME(a_ind_not_wet, aclk, aresetn,
                     m_tvalid && (m_tuser == '0) && (m_tdata[1:0] != LVL_WET), !m_tdata[2])

    `WPC_ASSERT_SAME(a_out_from_in, aclk, aresetn, $rose(m_tvalid),
                     $past(s_tvalid && s_tready, 2))

endmodule

bind water_presence_classifier_top wpc_checker u_wpc_checker (.*);
